FILE: rtl/fsqc_pkg.sv
// shared types and helper functions for the single-precision square root pipeline
`default_nettype none
package fsqc_pkg;

  // root iterations per pipeline stage and number of root stages
  localparam int IterPerStage = 2;
  localparam int RootStages   = 13;
  localparam int QW   = 26;   // raw root width, 24 bits plus guard and carry room
  localparam int RemW = 28;   // partial remainder width
  localparam int RadW = 52;   // radicand width, two bits per iteration

  localparam logic [31:0] PosZero = 32'h0000_0000;
  localparam logic [31:0] NegZero = 32'h8000_0000;
  localparam logic [31:0] PosInf  = 32'h7F80_0000;

  typedef struct packed {
    logic [31:0] operand_bits;
    logic        last_in;
  } in_t;

  typedef struct packed {
    logic [31:0] root_bits;
    logic        last_out;
  } out_t;

  // one item in flight
  typedef struct packed {
    logic            valid;
    logic            last;
    logic            special;
    logic [31:0]     spec_bits;
    logic [7:0]      re;
    logic [RadW-1:0] rad;
    logic [RemW-1:0] rem;
    logic [QW-1:0]   q;
  } pipe_t;

  // leading zeros of a 23-bit fraction
  function automatic logic [4:0] lzc23(input logic [22:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd23;
    found = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(22 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // one restoring root iteration: bring down two radicand bits, try a one
  function automatic pipe_t root_iter(input pipe_t p);
    pipe_t           r;
    logic [RemW-1:0] rem2;
    logic [RemW-1:0] trial;
    r = p;
    rem2  = {p.rem[RemW-3:0], p.rad[RadW-1 -: 2]};
    trial = {p.q[RemW-3:0], 2'b01};
    r.rad = {p.rad[RadW-3:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem = rem2 - trial;
      r.q   = {p.q[QW-2:0], 1'b1};
    end else begin
      r.rem = rem2;
      r.q   = {p.q[QW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/float_sqrt_clamp_negative.sv
// top level of the pipelined single-precision square root
// One item enters per cycle unless in_stall is high; each passes through one
// unpack and normalize stage, 13 root stages of two restoring iterations each, and the
// output register, which also rounds. Stages hold independently, so bubbles close
// up while the output is stalled. Negative and NaN operands give +0.0, -0.0 gives -0.0,
// +inf gives +inf, subnormals are normalized; rounding is to nearest even.
`default_nettype none
module float_sqrt_clamp_negative
  import fsqc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  // stage count is tied to the root width, so it comes from the package
  localparam int NumStages = RootStages;

  pipe_t p_r [NumStages+1];
  pipe_t p0_nxt;
  logic  hold [NumStages+1];
  logic  hold_out;
  out_t  out_r;
  out_t  out_nxt;
  logic  out_valid_r;

  // unpack, classify and normalize
  always_comb begin
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [4:0]  lz;
    logic [24:0] m;
    logic signed [9:0] e;
    sgn = in_data.operand_bits[31];
    ex  = in_data.operand_bits[30:23];
    man = in_data.operand_bits[22:0];
    lz  = lzc23(man);
    p0_nxt = '0;
    p0_nxt.valid = in_valid;
    p0_nxt.last  = in_data.last_in;
    if (in_data.operand_bits == NegZero) begin
      p0_nxt.special = 1'b1;
      p0_nxt.spec_bits = NegZero;
    end else if (sgn || (in_data.operand_bits == PosZero) || (ex == 8'hFF && man != '0)) begin
      p0_nxt.special = 1'b1;
      p0_nxt.spec_bits = PosZero;
    end else if (ex == 8'hFF) begin
      p0_nxt.special = 1'b1;
      p0_nxt.spec_bits = PosInf;
    end
    if (ex == 8'd0) begin
      m = {2'b00, man} << (lz + 5'd1);
      e = -10'(lz) - 10'sd127;
    end else begin
      m = {2'b01, man};
      e = 10'(ex) - 10'sd127;
    end
    // odd exponent folds one bit into the mantissa
    if (e[0]) begin
      m = {m[23:0], 1'b0};
      e = e - 10'sd1;
    end
    p0_nxt.re  = 8'((e >>> 1) + 10'sd127);
    p0_nxt.rad = {2'b00, m, 25'd0};
  end

  // hold chain from the output back to the input
  assign hold_out = out_valid_r & out_stall;
  assign hold[0]  = p_r[0].valid & hold[1];
  assign in_stall = hold[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r[0].valid <= 1'b0;
    end else if (!hold[0]) begin
      p_r[0] <= p0_nxt;
    end
  end

  // root stages
  for (genvar k = 1; k <= NumStages; k++) begin : g_stage
    logic hold_dn;
    if (k == NumStages) begin : g_end
      assign hold_dn = hold_out;
    end else begin : g_mid
      assign hold_dn = hold[k+1];
    end
    fsqc_stage #(.Iters(IterPerStage)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .prev    (p_r[k-1]),
      .hold_dn (hold_dn),
      .cur_r   (p_r[k]),
      .hold_up (hold[k])
    );
  end

  // round to nearest even and pack
  always_comb begin
    pipe_t       f;
    logic [24:0] q;
    logic [24:0] qr;
    logic [7:0]  re;
    logic        inc;
    f   = p_r[NumStages];
    q   = f.q[QW-1:1];
    inc = f.q[0] & ((f.rem != '0) | q[0]);
    qr  = q + 25'(inc);
    re  = f.re;
    if (qr[24]) begin
      qr = qr >> 1;
      re = re + 8'd1;
    end
    out_nxt.last_out = f.last;
    if (f.special) begin
      out_nxt.root_bits = f.spec_bits;
    end else begin
      out_nxt.root_bits = {1'b0, re, qr[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!hold_out) begin
      out_valid_r <= p_r[NumStages].valid;
      out_r       <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // only negative zero may leave with the sign bit set
  a_sign_only_negzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.root_bits[31]) |-> (out_r.root_bits[30:0] == '0))
    else $error("negative result other than -0.0");

  // input stalls only when the first stage holds an item
  a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> p_r[0].valid)
    else $error("input stalled with empty first stage");

  // a held last stage keeps its item
  a_last_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    hold[NumStages] |=> (p_r[NumStages].valid && $stable(p_r[NumStages].q)))
    else $error("held root stage changed");

  // finite nonzero results carry a nonzero exponent
  a_normal_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.root_bits[30:0] != '0) |-> (out_r.root_bits[30:23] != 8'd0))
    else $error("subnormal root produced");

endmodule
`default_nettype wire

FILE: rtl/fsqc_stage.sv
// one root pipeline stage: Iters restoring iterations behind a holdable register
`default_nettype none
module fsqc_stage
  import fsqc_pkg::*;
#(
  parameter int Iters = IterPerStage
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire pipe_t prev,
  input  wire logic  hold_dn,
  output pipe_t      cur_r,
  output logic       hold_up
);

  pipe_t cur_nxt;

  // iterations on the incoming item
  always_comb begin
    cur_nxt = prev;
    for (int i = 0; i < Iters; i++) begin
      cur_nxt = root_iter(cur_nxt);
    end
  end

  // stage holds only when it owns an item and downstream is blocked
  assign hold_up = cur_r.valid & hold_dn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.valid <= 1'b0;
    end else if (!hold_up) begin
      cur_r <= cur_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sim/sqrt_checker.sv
// checker for the square root pipeline: watches both channels, predicts and compares
module sqrt_checker
  import fsqc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   fail_count,
  output int   pending_roots
);
  timeunit 1ns;
  timeprecision 1ps;

  out_t expected_roots[$];

  // integer root of a 52-bit radicand, also telling whether it is exact
  function automatic logic [25:0] int_root(input logic [63:0] v, output logic exact);
    logic [63:0] q;
    logic [63:0] t;
    q = 0;
    for (int b = 25; b >= 0; b--) begin
      t = q | (64'd1 << b);
      if (t * t <= v) q = t;
    end
    exact = (q * q == v);
    return q[25:0];
  endfunction

  // correctly rounded root with the clamp for negative and nan operands
  function automatic logic [31:0] predict_root(input logic [31:0] x);
    logic [7:0]  ex;
    logic [22:0] frac;
    logic [63:0] m;
    logic [63:0] q;
    logic [25:0] q2;
    logic        exact;
    int          e;
    int          re;
    ex = x[30:23];
    frac = x[22:0];
    if (x == NegZero) return NegZero;
    if (ex == 8'hFF && frac != 0) return PosZero;
    if (x[31]) return PosZero;
    if (x == PosZero) return PosZero;
    if (ex == 8'hFF) return PosInf;
    if (ex == 0) begin
      m = frac;
      e = 1;
      while (m[23] == 1'b0) begin
        m = m << 1;
        e--;
      end
    end else begin
      m = {41'd0, 1'b1, frac};
      e = ex;
    end
    e = e - 127;
    if (e % 2 != 0) begin
      m = m << 1;
      e = e - 1;
    end
    q2 = int_root(m << 25, exact);
    q = q2 >> 1;
    if (q2[0] && (!exact || q[0])) q = q + 1;
    re = e / 2 + 127;
    if (q >= (64'd1 << 24)) begin
      q = q >> 1;
      re = re + 1;
    end
    return {1'b0, re[7:0], q[22:0]};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %08h expected %08h", what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending_roots = expected_roots.size();

  // predict on input acceptance, compare on output acceptance
  always @(posedge clk) begin
    out_t want;
    out_t pred;
    if (rst_n && in_valid && !in_stall) begin
      pred.root_bits = predict_root(in_data.operand_bits);
      pred.last_out = in_data.last_in;
      expected_roots.push_back(pred);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_roots.size() == 0) begin
        report_mismatch("unexpected item", out_data.root_bits, 32'h0);
      end else begin
        want = expected_roots.pop_front();
        if (out_data.root_bits !== want.root_bits)
          report_mismatch("root_bits", out_data.root_bits, want.root_bits);
        if (out_data.last_out !== want.last_out)
          report_mismatch("last_out", 32'(out_data.last_out), 32'(want.last_out));
      end
    end
  end
endmodule

FILE: sim/tb_top.sv
// testbench top: stimulus, stall pattern, watchdog and verdict for the square root pipeline
module tb_top
  import fsqc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 700;
  localparam int IdleLimit = 2000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  int   fail_count;
  int   pending_roots;
  int   idle_cycles;
  logic stim_done;
  logic hold_done;

  float_sqrt_clamp_negative DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  sqrt_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_roots(pending_roots)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // random operand weighted toward interesting classes
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hFF;
      2: v[30:0] = 31'($urandom_range(0, 3));
      3: v[31] = 1'b0;
      4: v[31] = 1'b0;
      5: begin
        v[31] = 1'b0;
        v[30:23] = 8'($urandom_range(120, 135));
      end
      default: ;
    endcase
    return v;
  endfunction

  // present one item and hold it until accepted
  task automatic send_item(input logic [31:0] bits, input logic last);
    in_valid <= 1'b1;
    in_data.operand_bits <= bits;
    in_data.last_in <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // receiver: one long hold-off, then a random stall pattern
  initial begin
    int hold;
    out_stall = 1'b1;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    hold = 0;
    while (hold < 80) begin
      @(posedge clk);
      hold++;
    end
    hold_done = 1'b1;
    forever begin
      case ($urandom_range(0, 3))
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 7) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // watchdog on cycles with nothing accepted
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    logic [31:0] directed[$];
    int burst;
    int sent;
    int tail;
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFFC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF,
                 32'h0000_0001, 32'h007F_FFFF, 32'h0040_0000, 32'h0080_0000,
                 32'h7F7F_FFFF, 32'h3F80_0000, 32'h4080_0000, 32'h4000_0000,
                 32'h4040_0000, 32'hBF80_0000, 32'h8000_0001, 32'h3F80_0001,
                 32'h4110_0000, 32'h7FFF_FFFF};
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed corners, back to back so the long hold-off fills the pipe
    foreach (directed[i]) send_item(directed[i], (i == directed.size() - 1));
    // keep offering during the hold-off
    while (!hold_done) send_item(pick_operand(), 1'(($urandom_range(0, 15) == 0)));
    // random bursts with gaps
    sent = 0;
    while (sent < NumRandom) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < NumRandom; k++) begin
        send_item(pick_operand(), 1'(($urandom_range(0, 15) == 0)));
        sent++;
      end
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    stim_done = 1'b1;
    @(posedge clk);
    while (pending_roots != 0) @(posedge clk);
    tail = 0;
    while (tail < 40) begin
      @(posedge clk);
      tail++;
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
